// File: rtl/core/led_alert_pattern_generator_core_assert.svh
// Assertion macros shared by the LED alert pattern generator RTL.
`ifndef LED_ALERT_PATTERN_GENERATOR_CORE_ASSERT_SVH
`define LED_ALERT_PATTERN_GENERATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Plain invariant, checked at every clock edge out of reset.
`define LAPG_ASSERT(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("%m: invariant violated");
// Same-cycle implication.
`define LAPG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: implication violated");
// Next-cycle implication.
`define LAPG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication violated");
`else
`define LAPG_ASSERT(label, expr)
`define LAPG_ASSERT_IMP(label, ante, cons)
`define LAPG_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/core/lapg_pkg.sv
// Shared constants, types and codes of the LED alert pattern generator.
package lapg_pkg;

    localparam int LED_NUMBER         = 7;
    localparam int STROBE_ON_TICKS    = 70;
    localparam int STROBE_OFF_TICKS   = 160;
    localparam int PING_RISE_TICKS    = 40;
    localparam int PING_DECAY_TICKS   = 1500;
    localparam int POLICE_FRAME_TICKS = 300;

    localparam int STROBE_PERIOD = STROBE_ON_TICKS + STROBE_OFF_TICKS;
    localparam int POLICE_PERIOD = 2 * POLICE_FRAME_TICKS;
    localparam int PING_TOTAL    = PING_RISE_TICKS + PING_DECAY_TICKS;
    localparam int RISE_DIV      = 2 * PING_RISE_TICKS;
    localparam int LED_HALF      = LED_NUMBER / 2;

    localparam int LED_CNT_W   = $clog2(LED_NUMBER);
    localparam int STROBE_PH_W = $clog2(STROBE_PERIOD);
    localparam int POLICE_PH_W = $clog2(POLICE_PERIOD);
    localparam int ROM_ADDR_W  = $clog2(PING_TOTAL);

    localparam int TICK_W        = 32;
    localparam int LEVEL_W       = 8;
    localparam int LED_IDX_W     = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int CMD_W         = 2;
    localparam int MODE_W        = 3;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 40;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL      = 8'd255;
    localparam logic [LEVEL_W-1:0] POLICE_BLUE_DIM = 8'd200;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE   = 3'd0,
        MODE_STEADY = 3'd1,
        MODE_STROBE = 3'd2,
        MODE_PING   = 3'd3,
        MODE_POLICE = 3'd4
    } t_mode;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RED        = 3'd0,
        CFG_GREEN      = 3'd1,
        CFG_BLUE       = 3'd2,
        CFG_WHITE      = 3'd3,
        CFG_BRIGHTNESS = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FRAME_FLAT     = 2'd0,
        FRAME_POLICE_A = 2'd1,
        FRAME_POLICE_B = 2'd2
    } t_frame_kind;

    // One frame: either a single colour for every LED, or a police split.
    typedef struct packed {
        t_frame_kind        kind;
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
        logic [LEVEL_W-1:0] white;
    } t_frame;

endpackage

// File: rtl/core/lapg_ping_rom.sv
// Ping envelope ROM: linear rise followed by the rounded exponential decay.
module lapg_ping_rom
    import lapg_pkg::*;
(
    input  logic                  i_clk,
    input  logic [ROM_ADDR_W-1:0] i_addr,
    output logic [LEVEL_W-1:0]    o_data
);

    localparam int ROM_BLOCKS = (PING_TOTAL + 63) / 64;

    typedef logic [LEVEL_W-1:0] t_ping_rom [PING_TOTAL];

    // Restoring shift-and-subtract division; only evaluated while the table
    // is built, so it never turns into logic.
    function automatic logic [63:0] udiv64(input logic [63:0] dividend,
                                           input logic [63:0] divisor);
        logic [63:0] quo;
        logic [63:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], dividend[b]};
            if (rem >= divisor) begin
                rem    = rem - divisor;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Rounded 255*exp(-5*idx/PING_DECAY_TICKS), from a floored Taylor series
    // in unsigned Q8.56 arithmetic.
    function automatic logic [LEVEL_W-1:0] decay_level(input int unsigned idx);
        longint unsigned num;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned e;
        longint unsigned v;
        longint unsigned d;
        longint unsigned q;
        longint unsigned rm;
        logic            done;
        num  = 64'(5) * 64'(idx);
        term = 64'd1 << 56;
        pos  = term;
        neg  = 64'd0;
        done = 1'b0;
        for (int n = 1; n < 64; n++) begin
            if (!done) begin
                d    = 64'(PING_DECAY_TICKS) * 64'(n);
                q    = udiv64(term, d);
                rm   = term - q * d;
                term = q * num + udiv64(rm * num, d);
                if (term == 64'd0) begin
                    done = 1'b1;
                end else if (n % 2 == 1) begin
                    neg = neg + term;
                end else begin
                    pos = pos + term;
                end
            end
        end
        e = (pos > neg) ? pos - neg : 64'd0;
        v = (64'd255 * e + (64'd1 << 55)) >> 56;
        return (v > 64'd255) ? LEVEL_FULL : v[LEVEL_W-1:0];
    endfunction

    // Built in blocks of 64 so that no single loop runs long at elaboration.
    function automatic t_ping_rom build_ping_rom();
        t_ping_rom   rom;
        int unsigned idx;
        int unsigned rise;
        for (int blk = 0; blk < ROM_BLOCKS; blk++) begin
            for (int lo = 0; lo < 64; lo++) begin
                idx = 32'(blk * 64 + lo);
                if (idx < PING_TOTAL) begin
                    if (idx < PING_RISE_TICKS) begin
                        rise     = 32'(udiv64(64'(32'd510 * idx + PING_RISE_TICKS),
                                              64'(RISE_DIV)));
                        rom[idx] = rise[LEVEL_W-1:0];
                    end else begin
                        rom[idx] = decay_level(idx - PING_RISE_TICKS);
                    end
                end
            end
        end
        return rom;
    endfunction

    localparam t_ping_rom PING_ROM = build_ping_rom();

    logic [LEVEL_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= PING_ROM[i_addr];
    end

    assign o_data = r_data;

endmodule

// File: rtl/core/lapg_frame_ctrl.sv
// Command decode, mode and tick state, configuration and frame descriptor.
module lapg_frame_ctrl
    import lapg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LEVEL_W-1:0]   i_cfg_data,
    input  logic                 i_in_valid,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic [MODE_W-1:0]    i_mode_sel,
    output logic                 o_in_ready,
    output t_frame               o_frame,
    output logic                 o_frame_valid,
    input  logic                 i_frame_take
);

    `include "led_alert_pattern_generator_core_assert.svh"

    t_mode                   r_mode, n_mode;
    logic [TICK_W-1:0]       r_elapsed, n_elapsed;
    logic [STROBE_PH_W-1:0]  r_strobe_ph, n_strobe_ph;
    logic [POLICE_PH_W-1:0]  r_police_ph, n_police_ph;
    logic [LEVEL_W-1:0]      r_red, r_green, r_blue, r_white, r_bright;
    t_frame                  r_frame, n_frame;
    logic                    r_frame_valid, n_frame_valid;

    logic                    accept;
    t_cmd                    cmd;
    logic                    ping_over;
    logic                    tick_frame;
    logic                    blank_frame;
    logic [ROM_ADDR_W-1:0]   rom_addr;
    logic [LEVEL_W-1:0]      rom_level;
    t_frame                  mode_frame;

    // floor(level * brightness / 255), exact over the whole 16-bit product.
    function automatic logic [LEVEL_W-1:0] scale255(input logic [LEVEL_W-1:0] level,
                                                     input logic [LEVEL_W-1:0] bright);
        logic [16:0] prod;
        logic [16:0] sum;
        prod = 17'(level) * 17'(bright) + 17'd1;
        sum  = prod + (prod >> 8);
        return sum[15:8];
    endfunction

    assign o_in_ready = !r_frame_valid;
    assign accept     = i_in_valid && o_in_ready;
    assign cmd        = t_cmd'(i_cmd);
    assign ping_over  = r_elapsed >= TICK_W'(PING_TOTAL);

    // Read at the next count so the registered data matches r_elapsed inside the table.
    always_comb begin
        if (!i_rst_n || (n_elapsed >= TICK_W'(PING_TOTAL))) begin
            rom_addr = '0;
        end else begin
            rom_addr = n_elapsed[ROM_ADDR_W-1:0];
        end
    end

    lapg_ping_rom u_ping_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_data (rom_level)
    );

    // Next state: mode, tick count and the two pattern phases.
    always_comb begin
        n_mode      = r_mode;
        n_elapsed   = r_elapsed;
        n_strobe_ph = r_strobe_ph;
        n_police_ph = r_police_ph;
        tick_frame  = 1'b0;
        blank_frame = 1'b0;
        if (accept) begin
            case (cmd)
                CMD_START: begin
                    n_mode      = (i_mode_sel <= MODE_POLICE) ? t_mode'(i_mode_sel)
                                                              : MODE_IDLE;
                    n_elapsed   = '0;
                    n_strobe_ph = '0;
                    n_police_ph = '0;
                end
                CMD_STOP: begin
                    n_mode      = MODE_IDLE;
                    blank_frame = 1'b1;
                end
                CMD_TICK: begin
                    if ((r_mode == MODE_PING) && ping_over) begin
                        n_mode      = MODE_IDLE;
                        blank_frame = 1'b1;
                    end else if (r_mode != MODE_IDLE) begin
                        tick_frame = 1'b1;
                        n_elapsed  = r_elapsed + 1'b1;
                        // The phases restart with the count when it wraps.
                        if ((r_elapsed == '1) ||
                            (r_strobe_ph == STROBE_PH_W'(STROBE_PERIOD - 1))) begin
                            n_strobe_ph = '0;
                        end else begin
                            n_strobe_ph = r_strobe_ph + 1'b1;
                        end
                        if ((r_elapsed == '1) ||
                            (r_police_ph == POLICE_PH_W'(POLICE_PERIOD - 1))) begin
                            n_police_ph = '0;
                        end else begin
                            n_police_ph = r_police_ph + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Frame colour for a tick in the current mode.
    always_comb begin
        mode_frame = '{kind: FRAME_FLAT, red: '0, green: '0, blue: '0, white: '0};
        unique case (r_mode)
            MODE_STEADY: begin
                mode_frame.red   = scale255(r_red, r_bright);
                mode_frame.green = scale255(r_green, r_bright);
                mode_frame.blue  = scale255(r_blue, r_bright);
                mode_frame.white = scale255(r_white, r_bright);
            end
            MODE_STROBE: begin
                if (r_strobe_ph < STROBE_PH_W'(STROBE_ON_TICKS)) begin
                    mode_frame.red   = LEVEL_FULL;
                    mode_frame.green = LEVEL_FULL;
                    mode_frame.blue  = LEVEL_FULL;
                    mode_frame.white = (r_white != '0) ? LEVEL_FULL : '0;
                end
            end
            MODE_PING: begin
                mode_frame.red   = rom_level >> 5;
                mode_frame.white = rom_level;
            end
            MODE_POLICE: begin
                mode_frame.kind = (r_police_ph < POLICE_PH_W'(POLICE_FRAME_TICKS))
                                  ? FRAME_POLICE_A : FRAME_POLICE_B;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_frame       = r_frame;
        n_frame_valid = r_frame_valid && !i_frame_take;
        if (tick_frame) begin
            n_frame       = mode_frame;
            n_frame_valid = 1'b1;
        end else if (blank_frame) begin
            n_frame       = '{kind: FRAME_FLAT, red: '0, green: '0, blue: '0, white: '0};
            n_frame_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_IDLE;
            r_elapsed     <= '0;
            r_strobe_ph   <= '0;
            r_police_ph   <= '0;
            r_frame_valid <= 1'b0;
            r_red         <= 8'd255;
            r_green       <= 8'd255;
            r_blue        <= 8'd255;
            r_white       <= 8'd0;
            r_bright      <= 8'd128;
        end else begin
            r_mode        <= n_mode;
            r_elapsed     <= n_elapsed;
            r_strobe_ph   <= n_strobe_ph;
            r_police_ph   <= n_police_ph;
            r_frame_valid <= n_frame_valid;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_RED:        r_red    <= i_cfg_data;
                    CFG_GREEN:      r_green  <= i_cfg_data;
                    CFG_BLUE:       r_blue   <= i_cfg_data;
                    CFG_WHITE:      r_white  <= i_cfg_data;
                    CFG_BRIGHTNESS: r_bright <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame <= n_frame;
    end

    assign o_frame       = r_frame;
    assign o_frame_valid = r_frame_valid;

    `LAPG_ASSERT_IMP(a_ping_count_bound, r_mode == MODE_PING, r_elapsed <= TICK_W'(PING_TOTAL))
    `LAPG_ASSERT(a_strobe_phase_range, r_strobe_ph <= STROBE_PH_W'(STROBE_PERIOD - 1))
    `LAPG_ASSERT(a_police_phase_range, r_police_ph <= POLICE_PH_W'(POLICE_PERIOD - 1))
    `LAPG_ASSERT_NEXT(a_start_clears, accept && (cmd == CMD_START), (r_elapsed == '0) && !r_frame_valid)

endmodule

// File: rtl/core/lapg_led_serializer.sv
// Frame serializer: one output word per LED behind a registered output stage.
module lapg_led_serializer
    import lapg_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_frame                 i_frame,
    input  logic                   i_frame_valid,
    output logic                   o_frame_take,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [LED_IDX_W-1:0]   o_led_index,
    output logic [LEVEL_W-1:0]     o_red,
    output logic [LEVEL_W-1:0]     o_green,
    output logic [LEVEL_W-1:0]     o_blue,
    output logic [LEVEL_W-1:0]     o_white,
    output logic                   o_last
);

    `include "led_alert_pattern_generator_core_assert.svh"

    logic                  r_busy;
    logic [LED_CNT_W-1:0]  r_led;
    t_frame                r_frame;
    logic                  r_out_valid;
    logic [LED_IDX_W-1:0]  r_out_index;
    logic [LEVEL_W-1:0]    r_out_red, r_out_green, r_out_blue, r_out_white;
    logic                  r_out_last;

    logic                  out_free;
    logic                  emit;
    logic                  led_last;
    logic                  led_low;
    logic [6:0]            led_ext;
    t_frame                led_colour;

    assign out_free     = !r_out_valid || i_out_ready;
    assign emit         = r_busy && out_free;
    assign led_last     = r_led == LED_CNT_W'(LED_NUMBER - 1);
    assign o_frame_take = i_frame_valid && (!r_busy || (emit && led_last));
    assign led_ext      = 7'(r_led);
    assign led_low      = led_ext < 7'(LED_HALF);

    always_comb begin
        led_colour = r_frame;
        case (r_frame.kind)
            FRAME_POLICE_A: begin
                led_colour.red   = '0;
                led_colour.green = '0;
                led_colour.blue  = led_low ? POLICE_BLUE_DIM : '0;
                led_colour.white = led_low ? '0 : LEVEL_FULL;
            end
            FRAME_POLICE_B: begin
                led_colour.red   = '0;
                led_colour.green = '0;
                led_colour.blue  = led_low ? '0 : LEVEL_FULL;
                led_colour.white = led_low ? LEVEL_FULL : '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_led       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_frame_take) begin
                r_busy <= 1'b1;
                r_led  <= '0;
            end else if (emit && led_last) begin
                r_busy <= 1'b0;
            end else if (emit) begin
                r_led <= r_led + 1'b1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_frame_take) begin
            r_frame <= i_frame;
        end
        if (emit) begin
            r_out_index <= led_ext[LED_IDX_W-1:0];
            r_out_red   <= led_colour.red;
            r_out_green <= led_colour.green;
            r_out_blue  <= led_colour.blue;
            r_out_white <= led_colour.white;
            r_out_last  <= led_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_led_index = r_out_index;
    assign o_red       = r_out_red;
    assign o_green     = r_out_green;
    assign o_blue      = r_out_blue;
    assign o_white     = r_out_white;
    assign o_last      = r_out_last;

    `LAPG_ASSERT_IMP(a_led_in_range, r_busy, r_led <= LED_CNT_W'(LED_NUMBER - 1))
    `LAPG_ASSERT_NEXT(a_take_restarts, o_frame_take, r_busy && (r_led == '0))
    `LAPG_ASSERT_IMP(a_last_on_final_led, r_out_valid && r_out_last, r_out_index == LED_IDX_W'(LED_NUMBER - 1))

endmodule

// File: rtl/core/led_alert_pattern_generator_core.sv
// Top level of the LED alert pattern generator core.
//
//  Channel      Direction  Word contents (lowest bit first)
//  s_axis_*     in         tuser: cmd[1:0]; tdata: mode_select[2:0], zero pad
//  m_axis_*     out        tdata: led_index, red, green, blue, white, zero pad;
//                          tlast: last_led
//  i_cfg_*      in         write enable, register index, 8-bit register value
//
// A start or an ignored command produces no frame. A tick in a lit mode or a
// stop produces LED_NUMBER output words, one per cycle out of the serializer
// when the sink keeps up; the next frame is taken as the last word is emitted.
// The input side holds one pending frame descriptor; it stalls only while that
// slot is full, so the next command is taken while the current frame drains.
// Ping levels come from a registered ROM addressed with the next tick count,
// so its data is ready in the same cycle that the tick arrives.
// Reset is synchronous and active low; it returns to idle with the count at
// zero and restores the default steady colour registers. No clearing pass.
// Configuration writes take effect on the next clock edge.
module led_alert_pattern_generator_core
    import lapg_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write port.
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [LEVEL_W-1:0]     i_cfg_data,
    // Command stream.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [2:0] mode_select, rest zero
    input  logic [CMD_W-1:0]       s_axis_tuser,   // [1:0] cmd
    // LED colour stream.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [2:0] led_index, [10:3] red,
                                                   // [18:11] green, [26:19] blue,
                                                   // [34:27] white, rest zero
    output logic                   m_axis_tlast
);

    t_frame                frame;
    logic                  frame_valid;
    logic                  frame_take;
    logic [LED_IDX_W-1:0]  led_index;
    logic [LEVEL_W-1:0]    red, green, blue, white;

    // Decodes each command word, tracks mode and elapsed ticks, and turns a
    // tick or a stop into a frame descriptor that the serializer expands per LED.
    lapg_frame_ctrl u_frame_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (s_axis_tvalid),
        .i_cmd         (s_axis_tuser),
        .i_mode_sel    (s_axis_tdata[MODE_W-1:0]),
        .o_in_ready    (s_axis_tready),
        .o_frame       (frame),
        .o_frame_valid (frame_valid),
        .i_frame_take  (frame_take)
    );

    lapg_led_serializer u_led_serializer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame       (frame),
        .i_frame_valid (frame_valid),
        .o_frame_take  (frame_take),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_led_index   (led_index),
        .o_red         (red),
        .o_green       (green),
        .o_blue        (blue),
        .o_white       (white),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {5'b0, white, blue, green, red, led_index};

endmodule
